@@ hdl/vmhap_pkg.sv @@
// Shared types and constants for the video memory host access port.
// Used by vmhap_ctrl and video_memory_host_access_port; no dependencies.
`default_nettype none

package vmhap_pkg;

   localparam int ADDR_W    = 16;
   localparam int MEM_DEPTH = 65536;
   localparam int KIND_W    = 3;
   localparam int BYTE_W    = 8;
   localparam int REQ_W     = 16;   // kind + data, padded to whole bytes

   typedef enum logic [KIND_W-1:0] {
      KIND_REG_READ  = 3'd0,
      KIND_REG_WRITE = 3'd1,
      KIND_MEM_READ  = 3'd2,
      KIND_MEM_WRITE = 3'd3,
      KIND_INIT_READ = 3'd4
   } kind_type;

   // register numbers
   localparam logic [3:0] REG_SELECT   = 4'h0;
   localparam logic [3:0] REG_CTRL_LO  = 4'h1;
   localparam logic [3:0] REG_CTRL_HI  = 4'h2;
   localparam logic [3:0] REG_ADDR_MIN = 4'h8;
   localparam logic [3:0] REG_BASE     = 4'h9;
   localparam logic [3:0] REG_ADD2_LO  = 4'hb;
   localparam logic [3:0] REG_ADD2_HI  = 4'he;
   localparam logic [3:0] REG_WRAP_END = 4'hf;

   localparam logic [ADDR_W-1:0] ADDR_RESET = 16'hffff;
   localparam logic [BYTE_W-1:0] INIT_BYTE  = 8'hff;

   // memory access and response for one accepted transaction
   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] wdata;
      logic [BYTE_W-1:0] resp_byte;   // answer when not a memory read
   } mem_req_type;

endpackage

`default_nettype wire

@@ hdl/vmhap_ctrl.sv @@
// Register file and pointer logic of the host access port.
// Turns each accepted memory read or write into one video memory access; uses vmhap_pkg.
`default_nettype none

module vmhap_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire vmhap_pkg::kind_type            kind,
   input  wire logic [vmhap_pkg::BYTE_W-1:0]   data,
   output vmhap_pkg::mem_req_type              mem_req
);

   // Only control 1/2 and address 1/7 are ever used, so only those are kept.
   logic [3:0]                     reg_ptr_ff, reg_ptr_in;
   logic [3:0]                     next_ptr_ff, next_ptr_in;
   logic [vmhap_pkg::BYTE_W-1:0]   ctrl_lo_ff, ctrl_lo_in;
   logic [vmhap_pkg::BYTE_W-1:0]   ctrl_hi_ff, ctrl_hi_in;
   logic [vmhap_pkg::ADDR_W-1:0]   addr1_ff, addr1_in;
   logic [vmhap_pkg::ADDR_W-1:0]   addr7_ff, addr7_in;
   logic [vmhap_pkg::ADDR_W-1:0]   row_col_ff, row_col_in;
   logic                           rc_pend_ff, rc_pend_in;
   logic                           base_pend_ff, base_pend_in;
   logic                           init_ff, init_in;
   logic                           sel_ff, sel_in;     // 0 write mode, 1 read mode
   logic [vmhap_pkg::ADDR_W-1:0]   xy_ff, xy_in;
   logic [vmhap_pkg::ADDR_W-1:0]   base_ff, base_in;

   logic [vmhap_pkg::ADDR_W-1:0]   pair_word;
   logic [vmhap_pkg::ADDR_W-1:0]   pair_sum;
   logic [vmhap_pkg::ADDR_W-1:0]   base_ld, xy_ld, acc_addr, acc_next;
   logic                           sel_mid, sel_new, use_xy;

   function automatic logic [vmhap_pkg::ADDR_W-1:0] ptr_advance(
      input logic [vmhap_pkg::ADDR_W-1:0] p,
      input logic [vmhap_pkg::ADDR_W-1:0] wrap_at,
      input logic [vmhap_pkg::ADDR_W-1:0] wrap_to
   );
      logic [vmhap_pkg::ADDR_W-1:0] q;
      q = p + 16'd1;
      return (q == wrap_at) ? wrap_to : q;
   endfunction

   assign pair_word = {ctrl_hi_ff, ctrl_lo_ff};
   assign pair_sum  = pair_word +
                      (((reg_ptr_ff >= vmhap_pkg::REG_ADD2_LO) &&
                        (reg_ptr_ff <= vmhap_pkg::REG_ADD2_HI)) ? 16'd2 : 16'd1);

   // pointer loads and selection for memory accesses
   always_comb begin
      if (kind == vmhap_pkg::KIND_MEM_READ) begin
         base_ld = base_pend_ff ? (init_ff ? addr1_ff : addr1_ff - 16'd1) : base_ff;
         sel_mid = base_pend_ff ? 1'b0 : sel_ff;
         xy_ld   = rc_pend_ff ? (init_ff ? row_col_ff : row_col_ff - 16'd1) : xy_ff;
         sel_new = rc_pend_ff ? 1'b1 : sel_mid;
         use_xy  = sel_new;
      end else begin
         base_ld = base_pend_ff ? addr1_ff : base_ff;
         sel_mid = base_pend_ff ? 1'b1 : sel_ff;
         xy_ld   = rc_pend_ff ? row_col_ff : xy_ff;
         sel_new = rc_pend_ff ? 1'b0 : sel_mid;
         use_xy  = !sel_new;
      end
      acc_addr = use_xy ? xy_ld : base_ld;
      acc_next = ptr_advance(acc_addr, addr7_ff, addr1_ff);
   end

   always_comb begin
      reg_ptr_in   = reg_ptr_ff;
      next_ptr_in  = next_ptr_ff;
      ctrl_lo_in   = ctrl_lo_ff;
      ctrl_hi_in   = ctrl_hi_ff;
      addr1_in     = addr1_ff;
      addr7_in     = addr7_ff;
      row_col_in   = row_col_ff;
      rc_pend_in   = rc_pend_ff;
      base_pend_in = base_pend_ff;
      init_in      = init_ff;
      sel_in       = sel_ff;
      xy_in        = xy_ff;
      base_in      = base_ff;
      mem_req      = '0;
      mem_req.addr  = acc_addr;
      mem_req.wdata = data;
      if (accept) begin
         unique case (kind) inside
            vmhap_pkg::KIND_REG_READ: begin
               reg_ptr_in = next_ptr_ff;
            end
            vmhap_pkg::KIND_REG_WRITE: begin
               if (reg_ptr_ff == vmhap_pkg::REG_SELECT) begin
                  reg_ptr_in  = data[3:0];
                  next_ptr_in = data[7:4];
               end else begin
                  reg_ptr_in = next_ptr_ff;
                  if (reg_ptr_ff < vmhap_pkg::REG_ADDR_MIN) begin
                     if (reg_ptr_ff == vmhap_pkg::REG_CTRL_LO) begin
                        ctrl_lo_in = data;
                        row_col_in = {ctrl_hi_ff, data};
                        rc_pend_in = 1'b1;
                     end else if (reg_ptr_ff == vmhap_pkg::REG_CTRL_HI) begin
                        ctrl_hi_in = data;
                        row_col_in = {data, ctrl_lo_ff};
                        rc_pend_in = 1'b1;
                     end
                  end else begin
                     if (reg_ptr_ff == vmhap_pkg::REG_BASE)
                        addr1_in = pair_sum;
                     if (reg_ptr_ff == vmhap_pkg::REG_WRAP_END)
                        addr7_in = pair_sum;
                     rc_pend_in   = 1'b0;
                     base_pend_in = (reg_ptr_ff == vmhap_pkg::REG_BASE);
                  end
               end
            end
            vmhap_pkg::KIND_MEM_READ, vmhap_pkg::KIND_MEM_WRITE: begin
               rc_pend_in   = 1'b0;
               base_pend_in = 1'b0;
               sel_in       = sel_new;
               reg_ptr_in   = '0;
               xy_in        = use_xy ? acc_next : xy_ld;
               base_in      = use_xy ? base_ld : acc_next;
               if (kind == vmhap_pkg::KIND_MEM_READ) begin
                  init_in       = 1'b0;
                  mem_req.rd_en = 1'b1;
               end else begin
                  mem_req.wr_en = 1'b1;
               end
            end
            vmhap_pkg::KIND_INIT_READ: begin
               init_in           = 1'b1;
               reg_ptr_in        = '0;
               mem_req.resp_byte = vmhap_pkg::INIT_BYTE;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_ptr_ff   <= '0;
         next_ptr_ff  <= '0;
         ctrl_lo_ff   <= '0;
         ctrl_hi_ff   <= '0;
         addr1_ff     <= vmhap_pkg::ADDR_RESET;
         addr7_ff     <= vmhap_pkg::ADDR_RESET;
         row_col_ff   <= '0;
         rc_pend_ff   <= 1'b0;
         base_pend_ff <= 1'b0;
         init_ff      <= 1'b0;
         sel_ff       <= 1'b0;
         xy_ff        <= '0;
         base_ff      <= '0;
      end else begin
         reg_ptr_ff   <= reg_ptr_in;
         next_ptr_ff  <= next_ptr_in;
         ctrl_lo_ff   <= ctrl_lo_in;
         ctrl_hi_ff   <= ctrl_hi_in;
         addr1_ff     <= addr1_in;
         addr7_ff     <= addr7_in;
         row_col_ff   <= row_col_in;
         rc_pend_ff   <= rc_pend_in;
         base_pend_ff <= base_pend_in;
         init_ff      <= init_in;
         sel_ff       <= sel_in;
         xy_ff        <= xy_in;
         base_ff      <= base_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/video_memory_host_access_port.sv @@
// Response path: an accepted request is registered in stage s1, then in the output register
// that drives rsp_tvalid; a low rsp_tready holds them and stops new requests.
// Takes one request per cycle when not held; a memory read or write needs a single
// video memory port access. Reset: synchronous; afterwards the video memory is zeroed
// one byte per cycle over all 65536 addresses, req_tready held low until the pass is done.
// Depends on vmhap_pkg and vmhap_ctrl; holds the video memory and the response path.
`default_nettype none

module video_memory_host_access_port (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [vmhap_pkg::REQ_W-1:0]   req_tdata,   // [2:0] kind, [10:3] data, rest 0
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [vmhap_pkg::BYTE_W-1:0]  rsp_tdata    // [7:0] read_data
);

   logic [vmhap_pkg::BYTE_W-1:0]   mem_ff [vmhap_pkg::MEM_DEPTH];
   logic [vmhap_pkg::BYTE_W-1:0]   mem_q_ff;

   logic                           clr_active_ff, clr_active_in;
   logic [vmhap_pkg::ADDR_W-1:0]   clr_addr_ff, clr_addr_in;

   logic                           s1_valid_ff, s1_valid_in;
   logic                           s1_mem_ff;
   logic [vmhap_pkg::BYTE_W-1:0]   s1_byte_ff;
   logic                           out_valid_ff, out_valid_in;
   logic [vmhap_pkg::BYTE_W-1:0]   out_data_ff;

   logic                           accept;
   logic                           s1_adv;
   logic                           wr_en;
   logic [vmhap_pkg::ADDR_W-1:0]   wr_addr;
   logic [vmhap_pkg::BYTE_W-1:0]   wr_data;
   vmhap_pkg::mem_req_type         mem_req;

   vmhap_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .kind    (vmhap_pkg::kind_type'(req_tdata[2:0])),
      .data    (req_tdata[10:3]),
      .mem_req (mem_req)
   );

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !clr_active_ff && (!s1_valid_ff || s1_adv);
   assign accept     = req_tvalid && req_tready;

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_tready);

   assign clr_active_in = clr_active_ff && (clr_addr_ff != vmhap_pkg::ADDR_RESET);
   assign clr_addr_in   = clr_addr_ff + 16'd1;

   assign wr_en   = clr_active_ff || mem_req.wr_en;
   assign wr_addr = clr_active_ff ? clr_addr_ff : mem_req.addr;
   assign wr_data = clr_active_ff ? '0 : mem_req.wdata;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem_ff[wr_addr] <= wr_data;
      if (mem_req.rd_en)
         mem_q_ff <= mem_ff[mem_req.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (clr_active_ff) begin
            clr_active_ff <= clr_active_in;
            clr_addr_ff   <= clr_addr_in;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload of the two response stages
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mem_ff  <= mem_req.rd_en;
         s1_byte_ff <= mem_req.resp_byte;
      end
      if (s1_adv)
         out_data_ff <= s1_mem_ff ? mem_q_ff : s1_byte_ff;
   end

endmodule

`default_nettype wire

@@ verif/vmhap_checker.sv @@
// Checker for the video memory host access port: watches both streams, predicts
// each response from its own copy of the register file and video memory, compares.
// Depends on vmhap_pkg; instantiated next to the block by tb_top.
module vmhap_checker
   import vmhap_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic              req_tready,
   input  wire logic [REQ_W-1:0]  req_tdata,   // [2:0] kind, [10:3] data, rest 0
   input  wire logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire logic [BYTE_W-1:0] rsp_tdata,   // [7:0] read_data
   output int                     mismatch_count,
   output int                     open_count,
   output int                     checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // address register slots that bound pointer travel
   localparam logic [2:0] START_SLOT = 3'(REG_BASE - REG_ADDR_MIN);
   localparam logic [2:0] WRAP_SLOT  = 3'(REG_WRAP_END - REG_ADDR_MIN);

   logic [3:0]        reg_ptr;
   logic [3:0]        follow_ptr;
   logic [BYTE_W-1:0] ctrl_regs [8];
   logic [ADDR_W-1:0] addr_regs [8];
   logic [ADDR_W-1:0] rowcol_word;
   logic              rowcol_pending;
   logic              base_pending;
   logic              init_seen;
   logic              read_mode;      // 1: xy pointer serves reads, base pointer writes
   logic [ADDR_W-1:0] xy_ptr;
   logic [ADDR_W-1:0] base_ptr;
   logic [BYTE_W-1:0] vram [MEM_DEPTH];

   logic [BYTE_W-1:0] expected_bytes [$];
   int                errors;
   int                compared;

   task automatic clear_model();
      reg_ptr        = REG_SELECT;
      follow_ptr     = REG_SELECT;
      rowcol_word    = '0;
      rowcol_pending = 1'b0;
      base_pending   = 1'b0;
      init_seen      = 1'b0;
      read_mode      = 1'b0;
      xy_ptr         = '0;
      base_ptr       = '0;
      for (int i = 0; i < 8; i++) begin
         ctrl_regs[i] = '0;
         addr_regs[i] = ADDR_RESET;
      end
      for (int i = 0; i < MEM_DEPTH; i++)
         vram[i] = '0;
   endtask

   function automatic logic [ADDR_W-1:0] ctrl_pair();
      return {ctrl_regs[3'(REG_CTRL_HI)], ctrl_regs[3'(REG_CTRL_LO)]};
   endfunction

   function automatic logic [ADDR_W-1:0] step_ptr(input logic [ADDR_W-1:0] p);
      logic [ADDR_W-1:0] n;
      n = p + 16'd1;
      return (n == addr_regs[WRAP_SLOT]) ? addr_regs[START_SLOT] : n;
   endfunction

   // applies one host transaction to the model and returns the byte it answers
   function automatic logic [BYTE_W-1:0] host_access(input kind_type k,
                                                     input logic [BYTE_W-1:0] d);
      logic [BYTE_W-1:0] rd;
      logic [3:0]        r;
      rd = '0;
      r  = reg_ptr;
      case (k)
         KIND_REG_READ: begin
            reg_ptr = follow_ptr;
         end
         KIND_REG_WRITE: begin
            if (r == REG_SELECT) begin
               reg_ptr    = d[3:0];
               follow_ptr = d[7:4];
            end else begin
               if (r < REG_ADDR_MIN) begin
                  ctrl_regs[r[2:0]] = d;
                  if (r == REG_CTRL_LO || r == REG_CTRL_HI) begin
                     rowcol_word    = ctrl_pair();
                     rowcol_pending = 1'b1;
                  end
               end else begin
                  addr_regs[r[2:0]] = ctrl_pair() +
                     ((r >= REG_ADD2_LO && r <= REG_ADD2_HI) ? 16'd2 : 16'd1);
                  rowcol_pending = 1'b0;
                  base_pending   = (r == REG_BASE);
               end
               reg_ptr = follow_ptr;
            end
         end
         KIND_MEM_READ: begin
            // a fresh pointer load backs up one byte unless an init read came first
            if (base_pending) begin
               base_pending = 1'b0;
               read_mode    = 1'b0;
               base_ptr     = init_seen ? addr_regs[START_SLOT]
                                        : addr_regs[START_SLOT] - 16'd1;
            end
            if (rowcol_pending) begin
               rowcol_pending = 1'b0;
               read_mode      = 1'b1;
               xy_ptr         = init_seen ? rowcol_word : rowcol_word - 16'd1;
            end
            init_seen = 1'b0;
            reg_ptr   = REG_SELECT;
            if (read_mode) begin
               rd     = vram[xy_ptr];
               xy_ptr = step_ptr(xy_ptr);
            end else begin
               rd       = vram[base_ptr];
               base_ptr = step_ptr(base_ptr);
            end
         end
         KIND_MEM_WRITE: begin
            if (base_pending) begin
               base_pending = 1'b0;
               read_mode    = 1'b1;
               base_ptr     = addr_regs[START_SLOT];
            end
            if (rowcol_pending) begin
               rowcol_pending = 1'b0;
               read_mode      = 1'b0;
               xy_ptr         = rowcol_word;
            end
            if (!read_mode) begin
               vram[xy_ptr] = d;
               xy_ptr       = step_ptr(xy_ptr);
            end else begin
               vram[base_ptr] = d;
               base_ptr       = step_ptr(base_ptr);
            end
            reg_ptr = REG_SELECT;
         end
         KIND_INIT_READ: begin
            init_seen = 1'b1;
            reg_ptr   = REG_SELECT;
            rd        = INIT_BYTE;
         end
         default: ;
      endcase
      return rd;
   endfunction

   always @(posedge clock) begin : monitor
      logic [BYTE_W-1:0] want;
      if (reset) begin
         clear_model();
         expected_bytes.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_bytes.push_back(host_access(kind_type'(req_tdata[KIND_W-1:0]),
                                                 req_tdata[KIND_W +: BYTE_W]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               $error("read_data: unexpected response, expected none, actual 0x%02h",
                      rsp_tdata);
               errors++;
            end else begin
               want = expected_bytes.pop_front();
               compared++;
               if (rsp_tdata !== want) begin
                  $error("read_data mismatch: expected 0x%02h, actual 0x%02h",
                         want, rsp_tdata);
                  errors++;
               end
            end
         end
      end
      mismatch_count <= errors;
      checked_count  <= compared;
      open_count     <= expected_bytes.size();
   end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for video_memory_host_access_port: drives directed and random host
// transactions with random pacing on both streams; vmhap_checker does the checking.
// Depends on vmhap_pkg, vmhap_checker and the block itself.
module tb_top
   import vmhap_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 900;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 10;

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;    // [2:0] kind, [10:3] data, rest 0
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [BYTE_W-1:0] rsp_tdata;          // [7:0] read_data

   int mismatch_count;
   int open_count;
   int checked_count;
   int cycle_count = 0;
   int items_sent  = 0;
   int mem_reads   = 0;
   int mem_writes  = 0;
   int init_reads  = 0;
   bit steady_req  = 1'b0;

   video_memory_host_access_port uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   vmhap_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .open_count     (open_count),
      .checked_count  (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // mostly short idles, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // addresses cluster in a few pages so reads find earlier writes
   function automatic logic [ADDR_W-1:0] pick_addr();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return {8'h00, 8'($urandom_range(0, 255))};
      if (r < 75) return {8'h01, 8'($urandom_range(0, 255))};
      if (r < 85) return {8'hff, 8'($urandom_range(0, 255))};
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [BYTE_W-1:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send(input kind_type k, input logic [BYTE_W-1:0] d);
      int gap;
      gap = steady_req ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W-KIND_W-BYTE_W){1'b0}}, d, k};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (k == KIND_MEM_READ) mem_reads++;
      if (k == KIND_MEM_WRITE) mem_writes++;
      if (k == KIND_INIT_READ) init_reads++;
   endtask

   // select a register with no follow-on, then write it
   task automatic write_reg(input logic [3:0] r, input logic [BYTE_W-1:0] d);
      send(KIND_REG_WRITE, {REG_SELECT, r});
      send(KIND_REG_WRITE, d);
   endtask

   task automatic load_pair(input logic [ADDR_W-1:0] w);
      write_reg(REG_CTRL_LO, w[7:0]);
      write_reg(REG_CTRL_HI, w[15:8]);
   endtask

   // brings the register pointer back to the select state
   task automatic sync_pointer();
      send($urandom_range(0, 1) ? KIND_INIT_READ : KIND_MEM_READ, any_byte());
   endtask

   task automatic xy_burst();
      logic [ADDR_W-1:0] start;
      int                n;
      start = pick_addr();
      n     = $urandom_range(1, 8);
      sync_pointer();
      load_pair(start);
      repeat (n) send(KIND_MEM_WRITE, any_byte());
      if ($urandom_range(0, 1)) send(KIND_INIT_READ, any_byte());
      load_pair(start);
      repeat (n + 1) send(KIND_MEM_READ, any_byte());
   endtask

   // sets a wrap window [start, start+len) and walks the pointers around it
   task automatic window_walk();
      logic [ADDR_W-1:0] start;
      int                len;
      int                n;
      start = pick_addr();
      len   = $urandom_range(2, 12);
      n     = $urandom_range(len, 3 * len);
      sync_pointer();
      if ($urandom_range(0, 2) == 0)
         write_reg(4'($urandom_range(REG_ADDR_MIN, REG_ADD2_HI)), any_byte());
      load_pair(start + 16'(len) - 16'd1);
      write_reg(REG_WRAP_END, any_byte());
      load_pair(start - 16'd1);
      write_reg(REG_BASE, any_byte());
      if ($urandom_range(0, 1))
         load_pair(start + 16'($urandom_range(0, len - 1)));
      if ($urandom_range(0, 1)) send(KIND_INIT_READ, any_byte());
      repeat (n) begin
         if ($urandom_range(0, 9) == 0)
            send(KIND_INIT_READ, any_byte());
         else
            send($urandom_range(0, 1) ? KIND_MEM_WRITE : KIND_MEM_READ, any_byte());
      end
   endtask

   task automatic register_mix();
      sync_pointer();
      repeat ($urandom_range(2, 8))
         send($urandom_range(0, 3) == 0 ? KIND_REG_READ : KIND_REG_WRITE, any_byte());
   endtask

   task automatic noise();
      repeat ($urandom_range(1, 6))
         send(kind_type'($urandom_range(KIND_REG_READ, KIND_INIT_READ)), any_byte());
   endtask

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Cycle limit reached with %0d responses outstanding", open_count);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : rsp_pacing
      int low;
      int high;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            low  = 0;
            high = $urandom_range(20, 100);
         end else begin
            low  = pick_gap();
            high = $urandom_range(1, 8);
         end
         if (low > 0) begin
            rsp_tready <= 1'b0;
            repeat (low) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat (high) @(posedge clock);
      end
   end

   initial begin : stimulus
      int directed_items;
      int pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: all kinds, byte extremes, wrap at the top of memory,
      // follow-on register, the +1 and window-end load, base load and wrap
      send(KIND_INIT_READ, 8'hff);
      send(KIND_MEM_READ, 8'h00);
      load_pair(16'hffff);
      send(KIND_MEM_WRITE, 8'ha5);
      send(KIND_MEM_WRITE, 8'h5a);
      write_reg(REG_CTRL_LO, 8'hff);
      send(KIND_MEM_READ, 8'h00);        // backs up to 0xfffe
      send(KIND_MEM_READ, 8'hff);
      send(KIND_REG_WRITE, {REG_WRAP_END, REG_CTRL_LO});
      send(KIND_REG_WRITE, 8'h0f);
      send(KIND_REG_WRITE, 8'h00);       // window end lands at 0xff10
      send(KIND_REG_READ, 8'hff);
      send(KIND_INIT_READ, 8'h00);
      write_reg(REG_CTRL_LO, 8'h0d);
      write_reg(REG_BASE, 8'hff);        // window start 0xff0e
      send(KIND_MEM_WRITE, 8'h11);
      send(KIND_MEM_WRITE, 8'h22);
      send(KIND_MEM_WRITE, 8'h33);       // wrapped back to the start
      send(KIND_MEM_READ, 8'h00);
      directed_items = items_sent;

      while (items_sent - directed_items < RANDOM_ITEMS) begin
         steady_req = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 35)      xy_burst();
         else if (pick < 65) window_walk();
         else if (pick < 85) register_mix();
         else                noise();
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d host transactions: %0d memory writes, %0d memory reads,",
               items_sent, mem_writes, mem_reads);
      $display("%0d init reads; compared %0d responses, pointer windows and register writes included",
               init_reads, checked_count);
      if (open_count != 0)
         $error("%0d responses never arrived", open_count);
      if (mismatch_count == 0 && open_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
